// ===== rtl/core/ucrh_pkg.sv =====
// Package for the USB control request handler: request/response types,
// request codes, the descriptor table and the HID report reply.
// No dependencies.
`default_nettype none

package ucrh_pkg;

  // Response actions
  typedef enum logic [2:0] {
    RspStall      = 3'd0,
    RspAck        = 3'd1,
    RspSendDesc   = 3'd2,
    RspSendImm    = 3'd3,
    RspSetAddr    = 3'd4,
    RspTakeOut    = 3'd5,
    RspConfigure  = 3'd6,
    RspResetDone  = 3'd7
  } rsp_e;

  // Standard request codes
  localparam logic [7:0] ReqGetStatus     = 8'd0;
  localparam logic [7:0] ReqSetAddress    = 8'd5;
  localparam logic [7:0] ReqGetDesc       = 8'd6;
  localparam logic [7:0] ReqGetConfig     = 8'd8;
  localparam logic [7:0] ReqSetConfig     = 8'd9;

  // HID class request codes
  localparam logic [7:0] HidGetReport     = 8'd1;
  localparam logic [7:0] HidGetIdle       = 8'd2;
  localparam logic [7:0] HidGetProtocol   = 8'd3;
  localparam logic [7:0] HidSetReport     = 8'd9;
  localparam logic [7:0] HidSetIdle       = 8'd10;
  localparam logic [7:0] HidSetProtocol   = 8'd11;

  // bmRequestType values
  localparam logic [7:0] TypeStdOutDevice = 8'h00;
  localparam logic [7:0] TypeStdInDevice  = 8'h80;
  localparam logic [7:0] TypeClassIn      = 8'hA1;
  localparam logic [7:0] TypeClassOut     = 8'h21;

  localparam logic [15:0] HidInterface    = 16'h0000;
  localparam logic [63:0] ReportReply     = 64'h0000_0000_0701_2621;

  localparam logic [7:0] MaxSendLength    = 8'd255;
  localparam logic [2:0] MaxPacketCount   = 3'd7;

  // Descriptor table: (wValue, wIndex, length)
  localparam int DescTableSize = 7;
  localparam logic [15:0] DescValue [DescTableSize] = '{
    16'h0100, 16'h0200, 16'h2100, 16'h2200, 16'h0300, 16'h0301, 16'h0302
  };
  localparam logic [15:0] DescIndex [DescTableSize] = '{
    16'h0000, 16'h0000, HidInterface, HidInterface, 16'h0000, 16'h0409, 16'h0409
  };
  localparam logic [7:0] DescLength [DescTableSize] = '{
    8'd18, 8'd34, 8'd9, 8'd112, 8'd4, 8'd16, 8'd48
  };

  typedef struct packed {
    logic        command;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
  } req_t;

  typedef struct packed {
    rsp_e        response;
    logic [2:0]  descriptor_select;
    logic [7:0]  send_length;
    logic [2:0]  packet_count;
    logic [63:0] immediate_data;
    logic [6:0]  device_address;
    logic [7:0]  configuration_value;
  } rsp_t;

  typedef struct packed {
    logic [7:0] configuration;
    logic [7:0] idle_rate;
    logic [7:0] protocol_mode;
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ucrh_if.sv =====
// Valid/ready channel interfaces for the USB control request handler:
// setup request channel and response channel. No dependencies.
`default_nettype none

interface ucrh_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_index;
  logic [15:0] request_length;

  modport source (
    output valid, command, request_type, request_code,
           request_value, request_index, request_length,
    input  ready
  );
  modport sink (
    input  valid, command, request_type, request_code,
           request_value, request_index, request_length,
    output ready
  );
endinterface

interface ucrh_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  response;
  logic [2:0]  descriptor_select;
  logic [7:0]  send_length;
  logic [2:0]  packet_count;
  logic [63:0] immediate_data;
  logic [6:0]  device_address;
  logic [7:0]  configuration_value;

  modport source (
    output valid, response, descriptor_select, send_length, packet_count,
           immediate_data, device_address, configuration_value,
    input  ready
  );
  modport sink (
    input  valid, response, descriptor_select, send_length, packet_count,
           immediate_data, device_address, configuration_value,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/usb_control_request_handler.sv =====
// Top level of the USB control request handler: input register, decoder,
// state registers and output register. Uses ucrh_pkg, ucrh_if, ucrh_decode.
//
//   channel  modport  direction  payload
//   req_i    sink     in         command, bmRequestType, bRequest, wValue, wIndex, wLength
//   rsp_o    source   out        response, descriptor, length, packets, data, address, config
//
// Each transaction passes through the input register and then the output
// register; with no stall a new transaction is taken every cycle, and the result
// is valid once it has been loaded into the output register.
// The decoder sits between the two registers and updates configuration, idle
// and protocol as the transaction moves forward.
// Reset empties both registers and loads configuration 0, idle 0, protocol 1.
// A stall on rsp_o holds the output register; the input register still fills if empty.
`default_nettype none

module usb_control_request_handler #(
  parameter int DESC_ENTRIES = 7,
  parameter int PACKET_BYTES = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ucrh_req_if.sink   req_i,
  ucrh_rsp_if.source rsp_o
);

  logic             in_valid_q;
  ucrh_pkg::req_t   req_q;
  logic             out_valid_q;
  ucrh_pkg::rsp_t   rsp_q;
  ucrh_pkg::state_t state_q, state_d;
  ucrh_pkg::rsp_t   rsp_d;
  logic             advance;
  logic             in_take;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign in_take     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q.command        <= req_i.command;
      req_q.request_type   <= req_i.request_type;
      req_q.request_code   <= req_i.request_code;
      req_q.request_value  <= req_i.request_value;
      req_q.request_index  <= req_i.request_index;
      req_q.request_length <= req_i.request_length;
    end
  end

  ucrh_decode #(
    .DESC_ENTRIES (DESC_ENTRIES),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_decode (
    .req_i   (req_q),
    .state_i (state_q),
    .rsp_o   (rsp_d),
    .state_o (state_d)
  );

  // Commit state only when the transaction moves into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.configuration <= 8'd0;
      state_q.idle_rate     <= 8'd0;
      state_q.protocol_mode <= 8'd1;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid               = out_valid_q;
  assign rsp_o.response            = rsp_q.response;
  assign rsp_o.descriptor_select   = rsp_q.descriptor_select;
  assign rsp_o.send_length         = rsp_q.send_length;
  assign rsp_o.packet_count        = rsp_q.packet_count;
  assign rsp_o.immediate_data      = rsp_q.immediate_data;
  assign rsp_o.device_address      = rsp_q.device_address;
  assign rsp_o.configuration_value = rsp_q.configuration_value;

endmodule

`default_nettype wire

// ===== rtl/core/ucrh_decode.sv =====
// Combinational request decoder: one setup packet or bus reset plus the
// current state in, one response and the next state out. Uses ucrh_pkg.
`default_nettype none

module ucrh_decode #(
  parameter int DESC_ENTRIES = 7,
  parameter int PACKET_BYTES = 64
) (
  input  ucrh_pkg::req_t   req_i,
  input  ucrh_pkg::state_t state_i,
  output ucrh_pkg::rsp_t   rsp_o,
  output ucrh_pkg::state_t state_o
);

  localparam int NumSearch = (DESC_ENTRIES < ucrh_pkg::DescTableSize) ?
                             DESC_ENTRIES : ucrh_pkg::DescTableSize;
  localparam int MaxExtraPackets = int'(ucrh_pkg::MaxPacketCount) - 1;

  logic       found;
  logic [2:0] sel;
  logic [7:0] entry_len;
  logic [7:0] len;
  logic [2:0] pkts;

  // Descriptor search; walk downward so the lowest matching entry wins.
  always_comb begin
    found     = 1'b0;
    sel       = 3'd0;
    entry_len = 8'd0;
    for (int i = NumSearch - 1; i >= 0; i--) begin
      if (ucrh_pkg::DescValue[i] == req_i.request_value &&
          ucrh_pkg::DescIndex[i] == req_i.request_index) begin
        found     = 1'b1;
        sel       = 3'(i);
        entry_len = ucrh_pkg::DescLength[i];
      end
    end
  end

  // Clamp to min(wLength, 255, entry length) and count IN packets.
  always_comb begin
    len = (|req_i.request_length[15:8]) ? ucrh_pkg::MaxSendLength
                                        : req_i.request_length[7:0];
    if (len > entry_len) begin
      len = entry_len;
    end
    pkts = 3'd1;
    for (int k = 1; k <= MaxExtraPackets; k++) begin
      if ({8'd0, len} >= 16'(k * PACKET_BYTES)) begin
        pkts = pkts + 3'd1;
      end
    end
  end

  always_comb begin
    state_o = state_i;
    rsp_o   = '0;
    rsp_o.response = ucrh_pkg::RspStall;

    if (req_i.command) begin
      state_o.configuration = 8'd0;
      rsp_o.response        = ucrh_pkg::RspResetDone;
    end else if (req_i.request_code == ucrh_pkg::ReqGetDesc) begin
      if (found) begin
        rsp_o.response          = ucrh_pkg::RspSendDesc;
        rsp_o.descriptor_select = sel;
        rsp_o.send_length       = len;
        rsp_o.packet_count      = pkts;
      end
    end else if (req_i.request_code == ucrh_pkg::ReqSetAddress) begin
      rsp_o.response       = ucrh_pkg::RspSetAddr;
      rsp_o.device_address = req_i.request_value[6:0];
    end else if (req_i.request_code == ucrh_pkg::ReqSetConfig &&
                 req_i.request_type == ucrh_pkg::TypeStdOutDevice) begin
      state_o.configuration = req_i.request_value[7:0];
      rsp_o.response        = ucrh_pkg::RspConfigure;
    end else if (req_i.request_code == ucrh_pkg::ReqGetConfig &&
                 req_i.request_type == ucrh_pkg::TypeStdInDevice) begin
      rsp_o.response       = ucrh_pkg::RspSendImm;
      rsp_o.send_length    = 8'd1;
      rsp_o.immediate_data = {56'd0, state_i.configuration};
    end else if (req_i.request_code == ucrh_pkg::ReqGetStatus) begin
      // two zero status bytes
      rsp_o.response    = ucrh_pkg::RspSendImm;
      rsp_o.send_length = 8'd2;
    end else if (req_i.request_index == ucrh_pkg::HidInterface) begin
      if (req_i.request_type == ucrh_pkg::TypeClassIn) begin
        case (req_i.request_code)
          ucrh_pkg::HidGetReport: begin
            rsp_o.response       = ucrh_pkg::RspSendImm;
            rsp_o.send_length    = 8'd8;
            rsp_o.immediate_data = ucrh_pkg::ReportReply;
          end
          ucrh_pkg::HidGetIdle: begin
            rsp_o.response       = ucrh_pkg::RspSendImm;
            rsp_o.send_length    = 8'd1;
            rsp_o.immediate_data = {56'd0, state_i.idle_rate};
          end
          ucrh_pkg::HidGetProtocol: begin
            rsp_o.response       = ucrh_pkg::RspSendImm;
            rsp_o.send_length    = 8'd1;
            rsp_o.immediate_data = {56'd0, state_i.protocol_mode};
          end
          default: begin
          end
        endcase
      end else if (req_i.request_type == ucrh_pkg::TypeClassOut) begin
        case (req_i.request_code)
          ucrh_pkg::HidSetReport: begin
            rsp_o.response = ucrh_pkg::RspTakeOut;
          end
          ucrh_pkg::HidSetIdle: begin
            state_o.idle_rate = req_i.request_value[15:8];
            rsp_o.response    = ucrh_pkg::RspAck;
          end
          ucrh_pkg::HidSetProtocol: begin
            state_o.protocol_mode = req_i.request_value[7:0];
            rsp_o.response        = ucrh_pkg::RspAck;
          end
          default: begin
          end
        endcase
      end
    end

    rsp_o.configuration_value = state_o.configuration;
  end

endmodule

`default_nettype wire
